/* src/cron_next_match_search_macros.svh */
// Assertion macros for the cron next-match search checker.
// Used only by cnms_checker.sv; no other dependencies.
`ifndef CRON_NEXT_MATCH_SEARCH_MACROS_SVH
`define CRON_NEXT_MATCH_SEARCH_MACROS_SVH

// same-cycle implication, disabled in reset
`define CNMS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cnms assertion failed");

// next-cycle implication, disabled in reset
`define CNMS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cnms assertion failed");

`endif

/* src/cnms_pkg.sv */
// Shared types, constants and calendar helpers for the cron next-match search.
// No dependencies.
package cnms_pkg;

   localparam int SEARCH_DAYS  = 1832;
   localparam int ELAPSED_W    = $clog2(SEARCH_DAYS + 2);
   localparam int YEAR_W       = 13;
   localparam int CYEAR_W      = 14;
   localparam int YEAR_BIAS    = 400;
   localparam int MAX_OUT_YEAR = 8191;
   localparam int ACC_W        = 14;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 3;
   localparam int STEP_W       = 3;
   localparam int REDUCE_STEPS = 5;   // 400 << 4 covers a biased 13-bit year
   localparam int MOD7_STEPS   = 7;   // 7 << 6 covers the weekday sum

   localparam logic [CSR_INDEX_W-1:0] REG_MINUTE_MASK  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HOUR_MASK    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MDAY_MASK    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MONTH_MASK   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_WDAY_MASK    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MDAY_LIMITED = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_WDAY_LIMITED = 3'd6;

   typedef struct packed {
      logic [59:0] minute_mask;
      logic [23:0] hour_mask;
      logic [31:0] mday_mask;
      logic [12:0] month_mask;
      logic [6:0]  wday_mask;
      logic        mday_limited;
      logic        wday_limited;
   } cfg_type;

   typedef struct packed {
      logic              load;
      logic              reduce;
      logic              prep;
      logic              mod7;
      logic              first;
      logic              search;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic search_done;
   } status_type;

   function automatic logic is_leap(input logic [8:0] m400);
      is_leap = (m400[1:0] == 2'd0) && (m400 != 9'd100) && (m400 != 9'd200)
                && (m400 != 9'd300);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      case (m) inside
         4'd2:                   month_len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
         default:                month_len = 5'd31;
      endcase
   endfunction

   // month offsets of the weekday formula, Sunday = 0
   function automatic logic [2:0] wday_offset(input logic [3:0] m);
      case (m)
         4'd1:    wday_offset = 3'd0;
         4'd2:    wday_offset = 3'd3;
         4'd3:    wday_offset = 3'd2;
         4'd4:    wday_offset = 3'd5;
         4'd5:    wday_offset = 3'd0;
         4'd6:    wday_offset = 3'd3;
         4'd7:    wday_offset = 3'd5;
         4'd8:    wday_offset = 3'd1;
         4'd9:    wday_offset = 3'd4;
         4'd10:   wday_offset = 3'd6;
         4'd11:   wday_offset = 3'd2;
         default: wday_offset = 3'd4;
      endcase
   endfunction

endpackage

/* src/cron_next_match_search.sv */
// Cron next-match search: first minute after a start time that passes the masks.
// Setup steps reduce the year mod 400 and the weekday sum mod 7; the search then
// checks candidate days in turn, retrying from the next allowed hour inside a day
// when an hour has no minute left, until a match or the end of the search window.
// One request at a time: the next is taken once the result beat has left.
// Synchronous active-high reset: idle, masks back to all-allowed, flags clear.
module cron_next_match_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cnms_pkg::YEAR_W-1:0]         req_in_year,
   input  logic [3:0]                          req_in_month,
   input  logic [4:0]                          req_in_day,
   input  logic [4:0]                          req_in_hour,
   input  logic [5:0]                          req_in_minute,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [cnms_pkg::YEAR_W-1:0]         rsp_out_year,
   output logic [3:0]                          rsp_out_month,
   output logic [4:0]                          rsp_out_day,
   output logic [4:0]                          rsp_out_hour,
   output logic [5:0]                          rsp_out_minute,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cnms_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cnms_pkg::CSR_DATA_W-1:0]     csr_data
);
   import cnms_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   cnms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cnms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cnms_dp u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg),
      .in_year    (req_in_year),
      .in_month   (req_in_month),
      .in_day     (req_in_day),
      .in_hour    (req_in_hour),
      .in_minute  (req_in_minute),
      .found      (rsp_found),
      .out_year   (rsp_out_year),
      .out_month  (rsp_out_month),
      .out_day    (rsp_out_day),
      .out_hour   (rsp_out_hour),
      .out_minute (rsp_out_minute)
   );

endmodule

/* src/cnms_csr.sv */
// Configuration registers of the cron next-match search.
// Depends on cnms_pkg.
module cnms_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [cnms_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cnms_pkg::CSR_DATA_W-1:0]     csr_data,
   output cnms_pkg::cfg_type                   cfg
);
   import cnms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MINUTE_MASK:  cfg_in.minute_mask  = csr_data[59:0];
            REG_HOUR_MASK:    cfg_in.hour_mask    = csr_data[23:0];
            REG_MDAY_MASK:    cfg_in.mday_mask    = csr_data[31:0];
            REG_MONTH_MASK:   cfg_in.month_mask   = csr_data[12:0];
            REG_WDAY_MASK:    cfg_in.wday_mask    = csr_data[6:0];
            REG_MDAY_LIMITED: cfg_in.mday_limited = csr_data[0];
            REG_WDAY_LIMITED: cfg_in.wday_limited = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.minute_mask  <= {60{1'b1}};
         cfg_ff.hour_mask    <= {24{1'b1}};
         cfg_ff.mday_mask    <= 32'hFFFF_FFFE;
         cfg_ff.month_mask   <= 13'h1FFE;
         cfg_ff.wday_mask    <= 7'h7F;
         cfg_ff.mday_limited <= 1'b0;
         cfg_ff.wday_limited <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/cnms_ctrl.sv */
// Sequencer of the cron next-match search: setup steps, search, result hold.
// Depends on cnms_pkg.
module cnms_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  cnms_pkg::status_type   status,
   output cnms_pkg::cmd_type      cmd
);
   import cnms_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_REDUCE = 7'b0000010,
      ST_PREP   = 7'b0000100,
      ST_MOD7   = 7'b0001000,
      ST_FIRST  = 7'b0010000,
      ST_SEARCH = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_REDUCE;
               step_in  = STEP_W'(REDUCE_STEPS - 1);
            end
         end
         ST_REDUCE: begin
            if (step_ff == '0) state_in = ST_PREP;
            else               step_in  = step_ff - 1'b1;
         end
         ST_PREP: begin
            state_in = ST_MOD7;
            step_in  = STEP_W'(MOD7_STEPS - 1);
         end
         ST_MOD7: begin
            if (step_ff == '0) state_in = ST_FIRST;
            else               step_in  = step_ff - 1'b1;
         end
         ST_FIRST:  state_in = ST_SEARCH;
         ST_SEARCH: if (status.search_done) state_in = ST_DONE;
         ST_DONE:   if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.reduce = (state_ff == ST_REDUCE);
      cmd.prep   = (state_ff == ST_PREP);
      cmd.mod7   = (state_ff == ST_MOD7);
      cmd.first  = (state_ff == ST_FIRST);
      cmd.search = (state_ff == ST_SEARCH);
      cmd.step   = step_ff;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

/* src/cnms_dp.sv */
// Datapath of the cron next-match search: date registers, weekday setup,
// one-day-per-cycle candidate evaluation (a day is held while hours are retried) and result registers.
// Depends on cnms_pkg.
module cnms_dp (
   input  logic                          clock,
   input  cnms_pkg::cmd_type             cmd,
   output cnms_pkg::status_type          status,
   input  cnms_pkg::cfg_type             cfg,
   input  logic [cnms_pkg::YEAR_W-1:0]   in_year,
   input  logic [3:0]                    in_month,
   input  logic [4:0]                    in_day,
   input  logic [4:0]                    in_hour,
   input  logic [5:0]                    in_minute,
   output logic                          found,
   output logic [cnms_pkg::YEAR_W-1:0]   out_year,
   output logic [3:0]                    out_month,
   output logic [4:0]                    out_day,
   output logic [4:0]                    out_hour,
   output logic [5:0]                    out_minute
);
   import cnms_pkg::*;

   function automatic logic [5:0] first_hour(input logic [23:0] mask, input logic [4:0] from);
      logic [5:0] r;
      r = '0;
      for (int v = 23; v >= 0; v--) begin
         if (5'(v) >= from && mask[v]) r = {1'b1, 5'(v)};
      end
      return r;
   endfunction

   function automatic logic [6:0] first_minute(input logic [59:0] mask,
                                               input logic [5:0] from);
      logic [6:0] r;
      r = '0;
      for (int v = 59; v >= 0; v--) begin
         if (6'(v) >= from && mask[v]) r = {1'b1, 6'(v)};
      end
      return r;
   endfunction

   logic [CYEAR_W-1:0]   year_ff, year_in;
   logic [3:0]           month_ff, month_in;
   logic [4:0]           day_ff, day_in;
   logic [4:0]           hour_ff, hour_in;
   logic [5:0]           minute_ff, minute_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [8:0]           m400_ff, m400_in;
   logic [2:0]           wday_ff, wday_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 res_found_ff, res_found_in;
   logic [YEAR_W-1:0]    res_year_ff, res_year_in;
   logic [3:0]           res_month_ff, res_month_in;
   logic [4:0]           res_day_ff, res_day_in;
   logic [4:0]           res_hour_ff, res_hour_in;
   logic [5:0]           res_minute_ff, res_minute_in;

   // next calendar day from the current one
   logic [CYEAR_W-1:0]   nd_year;
   logic [3:0]           nd_month;
   logic [4:0]           nd_day;
   logic [8:0]           nd_m400;
   logic [2:0]           nd_wday;
   logic [4:0]           cur_len;

   always_comb begin
      cur_len  = month_len(month_ff, is_leap(m400_ff));
      nd_year  = year_ff;
      nd_month = month_ff;
      nd_m400  = m400_ff;
      nd_day   = day_ff + 5'd1;
      if (day_ff >= cur_len) begin
         nd_day = 5'd1;
         if (month_ff >= 4'd12) begin
            nd_month = 4'd1;
            nd_year  = year_ff + 1'b1;
            nd_m400  = (m400_ff == 9'd399) ? 9'd0 : m400_ff + 9'd1;
         end else begin
            nd_month = month_ff + 4'd1;
         end
      end
      nd_wday = (wday_ff == 3'd6) ? 3'd0 : wday_ff + 3'd1;
   end

   // setup arithmetic
   logic [ACC_W-1:0] thr;
   logic [8:0]       r400, rp;
   logic [4:0]       plen, dclamp;
   logic [1:0]       c100;
   logic [9:0]       wsum;

   always_comb begin
      thr    = cmd.reduce ? (ACC_W'(YEAR_BIAS) << cmd.step) : (ACC_W'(7) << cmd.step);
      r400   = acc_ff[8:0];
      plen   = month_len(month_ff, is_leap(r400));
      dclamp = (day_ff == 5'd0) ? 5'd1 : (day_ff > plen) ? plen : day_ff;
      // Jan and Feb count in the previous year
      rp     = (month_ff <= 4'd2) ? ((r400 == 9'd0) ? 9'd399 : r400 - 9'd1) : r400;
      c100   = (rp >= 9'd300) ? 2'd3 : (rp >= 9'd200) ? 2'd2 : (rp >= 9'd100) ? 2'd1 : 2'd0;
      // the 400-year part contributes a multiple of seven and drops out
      wsum   = 10'(rp) + 10'(rp[8:2]) + 10'(wday_offset(month_ff)) + 10'(dclamp)
               - 10'(c100);
   end

   // candidate evaluation
   logic       exhausted, month_ok, dom_ok, dow_ok, day_ok;
   logic [5:0] hsel;
   logic [6:0] msel;
   logic [5:0] mstart;
   logic       year_fits;

   always_comb begin
      exhausted = elapsed_ff > ELAPSED_W'(SEARCH_DAYS);
      month_ok  = cfg.month_mask[month_ff];
      dom_ok    = cfg.mday_mask[day_ff];
      dow_ok    = cfg.wday_mask[wday_ff];
      case ({cfg.mday_limited, cfg.wday_limited})
         2'b00:   day_ok = 1'b1;
         2'b01:   day_ok = dow_ok;
         2'b10:   day_ok = dom_ok;
         default: day_ok = dom_ok || dow_ok;
      endcase
      hsel      = first_hour(cfg.hour_mask, hour_ff);
      mstart    = (hsel[4:0] == hour_ff) ? minute_ff : 6'd0;
      msel      = first_minute(cfg.minute_mask, mstart);
      year_fits = year_ff <= CYEAR_W'(MAX_OUT_YEAR);
   end

   assign status.search_done = cmd.search &&
                               (exhausted || (month_ok && day_ok && hsel[5] && msel[6]));

   always_comb begin
      year_in       = year_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      acc_in        = acc_ff;
      m400_in       = m400_ff;
      wday_in       = wday_ff;
      elapsed_in    = elapsed_ff;
      res_found_in  = res_found_ff;
      res_year_in   = res_year_ff;
      res_month_in  = res_month_ff;
      res_day_in    = res_day_ff;
      res_hour_in   = res_hour_ff;
      res_minute_in = res_minute_ff;

      if (cmd.load) begin
         year_in    = CYEAR_W'(in_year);
         month_in   = (in_month == 4'd0) ? 4'd1 : (in_month > 4'd12) ? 4'd12 : in_month;
         day_in     = in_day;
         hour_in    = (in_hour > 5'd23) ? 5'd23 : in_hour;
         minute_in  = (in_minute > 6'd59) ? 6'd59 : in_minute;
         acc_in     = ACC_W'(in_year) + ACC_W'(YEAR_BIAS);
         elapsed_in = '0;
      end else if (cmd.reduce || cmd.mod7) begin
         if (acc_ff >= thr) acc_in = acc_ff - thr;
      end else if (cmd.prep) begin
         m400_in = r400;
         day_in  = dclamp;
         acc_in  = ACC_W'(wsum);
      end else if (cmd.first) begin
         wday_in = acc_ff[2:0];
         if (minute_ff != 6'd59) begin
            minute_in = minute_ff + 6'd1;
         end else if (hour_ff != 5'd23) begin
            minute_in = 6'd0;
            hour_in   = hour_ff + 5'd1;
         end else begin
            year_in    = nd_year;
            month_in   = nd_month;
            day_in     = nd_day;
            m400_in    = nd_m400;
            wday_in    = (acc_ff[2:0] == 3'd6) ? 3'd0 : acc_ff[2:0] + 3'd1;
            elapsed_in = elapsed_ff + 1'b1;
            hour_in    = 5'd0;
            minute_in  = 6'd0;
         end
      end else if (cmd.search) begin
         if (exhausted) begin
            res_found_in  = 1'b0;
            res_year_in   = '0;
            res_month_in  = '0;
            res_day_in    = '0;
            res_hour_in   = '0;
            res_minute_in = '0;
         end else if (!month_ok || !day_ok || !hsel[5] ||
                      (!msel[6] && hsel[4:0] == 5'd23)) begin
            year_in    = nd_year;
            month_in   = nd_month;
            day_in     = nd_day;
            m400_in    = nd_m400;
            wday_in    = nd_wday;
            elapsed_in = elapsed_ff + 1'b1;
            hour_in    = 5'd0;
            minute_in  = 6'd0;
         end else if (msel[6]) begin
            res_found_in  = year_fits;
            res_year_in   = year_fits ? year_ff[YEAR_W-1:0] : '0;
            res_month_in  = year_fits ? month_ff : 4'd0;
            res_day_in    = year_fits ? day_ff : 5'd0;
            res_hour_in   = year_fits ? hsel[4:0] : 5'd0;
            res_minute_in = year_fits ? msel[5:0] : 6'd0;
         end else begin
            // hour has no minute left: retry from the next hour
            hour_in   = hsel[4:0] + 5'd1;
            minute_in = 6'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      year_ff       <= year_in;
      month_ff      <= month_in;
      day_ff        <= day_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      acc_ff        <= acc_in;
      m400_ff       <= m400_in;
      wday_ff       <= wday_in;
      elapsed_ff    <= elapsed_in;
      res_found_ff  <= res_found_in;
      res_year_ff   <= res_year_in;
      res_month_ff  <= res_month_in;
      res_day_ff    <= res_day_in;
      res_hour_ff   <= res_hour_in;
      res_minute_ff <= res_minute_in;
   end

   assign found      = res_found_ff;
   assign out_year   = res_year_ff;
   assign out_month  = res_month_ff;
   assign out_day    = res_day_ff;
   assign out_hour   = res_hour_ff;
   assign out_minute = res_minute_ff;

endmodule

/* src/cnms_checker.sv */
// Port-level checks for the cron next-match search, bound to the top level.
// Depends on cnms_pkg and cron_next_match_search_macros.svh.
`include "cron_next_match_search_macros.svh"

module cnms_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_found,
   input logic [cnms_pkg::YEAR_W-1:0]         rsp_out_year,
   input logic [3:0]                          rsp_out_month,
   input logic [4:0]                          rsp_out_day,
   input logic [4:0]                          rsp_out_hour,
   input logic [5:0]                          rsp_out_minute
);
   import cnms_pkg::*;

   logic        miss_zero;
   logic        hit_range;
   logic [33:0] rsp_payload;

   assign miss_zero = (rsp_out_year == '0) && (rsp_out_month == 4'd0) &&
                      (rsp_out_day == 5'd0) && (rsp_out_hour == 5'd0) &&
                      (rsp_out_minute == 6'd0);
   assign hit_range = (rsp_out_month >= 4'd1) && (rsp_out_month <= 4'd12) &&
                      (rsp_out_day >= 5'd1) && (rsp_out_hour <= 5'd23) &&
                      (rsp_out_minute <= 6'd59);
   assign rsp_payload = {rsp_found, rsp_out_year, rsp_out_month, rsp_out_day,
                         rsp_out_hour, rsp_out_minute};

   // a miss carries an all-zero date
   `CNMS_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_found, miss_zero)

   // a hit has its month, hour and minute in range and a nonzero day
   `CNMS_ASSERT_NOW(a_hit_range, rsp_valid && rsp_found, hit_range)

   // the setup steps keep the result away for at least the next cycle
   `CNMS_ASSERT_NEXT(a_no_instant_rsp, req_valid && !req_stall, !rsp_valid && req_stall)

   // a held result beat keeps its payload
   `CNMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind cron_next_match_search cnms_checker u_cnms_checker (.*);

/* test/cron_next_match_search_tb.sv */
// Testbench for cron_next_match_search: calendar search predictor plus scoreboard.
// Depends on cnms_pkg (register indexes, widths) and the cron_next_match_search RTL.
`timescale 1ns / 100ps

class cron_scoreboard;
   typedef struct packed {
      logic        found;
      logic [12:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
   } fire_type;

   fire_type pending_fires[$];
   int       errors;

   logic [59:0] minute_mask = 60'h0FFF_FFFF_FFFF_FFFF;
   logic [23:0] hour_mask   = 24'hFF_FFFF;
   logic [31:0] mday_mask   = 32'hFFFF_FFFE;
   logic [12:0] month_mask  = 13'h1FFE;
   logic [6:0]  wday_mask   = 7'h7F;
   logic        mday_limited = 1'b0;
   logic        wday_limited = 1'b0;

   function void write_reg(int idx, logic [63:0] v);
      case (idx)
         cnms_pkg::REG_MINUTE_MASK:  minute_mask = v[59:0];
         cnms_pkg::REG_HOUR_MASK:    hour_mask = v[23:0];
         cnms_pkg::REG_MDAY_MASK:    mday_mask = v[31:0];
         cnms_pkg::REG_MONTH_MASK:   month_mask = v[12:0];
         cnms_pkg::REG_WDAY_MASK:    wday_mask = v[6:0];
         cnms_pkg::REG_MDAY_LIMITED: mday_limited = v[0];
         cnms_pkg::REG_WDAY_LIMITED: wday_limited = v[0];
         default: ;
      endcase
   endfunction

   function bit leap_year(longint y);
      return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
   endfunction

   function longint month_days(longint y, longint m);
      int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m == 2 && leap_year(y)) return 29;
      return lens[(m - 1) % 12];
   endfunction

   // serial day, origin 0000-03-01, years biased by one 400-year era
   function longint serial_day(longint y, longint m, longint d);
      longint yy, era, yoe, mp, doy;
      yy = y + 400 - (m <= 2 ? 1 : 0);
      era = yy / 400;
      yoe = yy - era * 400;
      mp = (m + 9) % 12;
      doy = (153 * mp + 2) / 5 + d - 1;
      return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 146097;
   endfunction

   function void to_date(longint z, output longint y, output longint m, output longint d);
      longint zz, era, doe, yoe, doy, mp;
      zz = z + 146097;
      era = zz / 146097;
      doe = zz - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      d = doy - (153 * mp + 2) / 5 + 1;
      m = mp < 10 ? mp + 3 : mp - 9;
      y = yoe + era * 400 + (m <= 2 ? 1 : 0) - 400;
   endfunction

   function int first_allowed(logic [63:0] mask, longint from, longint top);
      for (longint v = from; v <= top; v++)
         if (mask[v]) return int'(v);
      return -1;
   endfunction

   function bit day_allowed(longint dom, longint dow);
      bit dom_ok, dow_ok;
      dom_ok = mday_mask[dom & 31];
      dow_ok = wday_mask[dow % 7];
      if (!mday_limited && !wday_limited) return 1;
      if (!mday_limited) return dow_ok;
      if (!wday_limited) return dom_ok;
      return dom_ok || dow_ok;
   endfunction

   function fire_type next_fire(logic [12:0] iy, logic [3:0] im, logic [4:0] id,
                                logic [4:0] ih, logic [5:0] imin);
      fire_type r;
      longint y, mo, d, h, mi, cday, cmin, last_day, cy, cm, cd, hr;
      int nm, nh, nmin;
      r = '{1'b0, 13'd0, 4'd0, 5'd0, 5'd0, 6'd0};
      y = iy; mo = im; d = id; h = ih; mi = imin;
      if (mo < 1) mo = 1;
      if (mo > 12) mo = 12;
      if (d < 1) d = 1;
      if (d > month_days(y, mo)) d = month_days(y, mo);
      if (h > 23) h = 23;
      if (mi > 59) mi = 59;
      cday = serial_day(y, mo, d);
      last_day = cday + cnms_pkg::SEARCH_DAYS;
      cmin = h * 60 + mi + 1;
      if (cmin >= 1440) begin
         cmin = 0;
         cday++;
      end
      while (cday <= last_day) begin
         to_date(cday, cy, cm, cd);
         nm = first_allowed(64'(month_mask), cm, 12);
         if (nm < 0) begin
            cday = serial_day(cy + 1, 1, 1);
            cmin = 0;
            continue;
         end
         if (nm != cm) begin
            cday = serial_day(cy, nm, 1);
            cmin = 0;
            continue;
         end
         if (!day_allowed(cd, (cday + 3) % 7)) begin
            cday++;
            cmin = 0;
            continue;
         end
         hr = cmin / 60;
         nh = first_allowed(64'(hour_mask), hr, 23);
         if (nh < 0) begin
            cday++;
            cmin = 0;
            continue;
         end
         if (nh != hr) begin
            hr = nh;
            cmin = hr * 60;
         end
         nmin = first_allowed(64'(minute_mask), cmin % 60, 59);
         if (nmin >= 0) begin
            if (cy <= cnms_pkg::MAX_OUT_YEAR)
               r = '{1'b1, 13'(cy), 4'(cm), 5'(cd), 5'(hr), 6'(nmin)};
            return r;
         end
         cmin = (hr + 1) * 60;
         if (cmin >= 1440) begin
            cmin = 0;
            cday++;
         end
      end
      return r;
   endfunction

   function void note_request(logic [12:0] y, logic [3:0] m, logic [4:0] d,
                              logic [4:0] h, logic [5:0] mi);
      pending_fires.push_back(next_fire(y, m, d, h, mi));
   endfunction

   task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   task check_fire(fire_type got);
      fire_type want;
      if (pending_fires.size() == 0) begin
         report("unexpected result beat");
         return;
      end
      want = pending_fires.pop_front();
      if (got !== want)
         report($sformatf("got f%0d %0d-%0d-%0d %0d:%0d want f%0d %0d-%0d-%0d %0d:%0d",
                          got.found, got.year, got.month, got.day, got.hour, got.minute,
                          want.found, want.year, want.month, want.day, want.hour,
                          want.minute));
   endtask
endclass

module cron_next_match_search_tb;
   import cnms_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [12:0] req_in_year = '0;
   logic [3:0]  req_in_month = '0;
   logic [4:0]  req_in_day = '0;
   logic [4:0]  req_in_hour = '0;
   logic [5:0]  req_in_minute = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [12:0] rsp_out_year;
   logic [3:0]  rsp_out_month;
   logic [4:0]  rsp_out_day;
   logic [4:0]  rsp_out_hour;
   logic [5:0]  rsp_out_minute;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int send_idle_pct = 32;
   int recv_idle_pct = 49;
   cron_scoreboard fire_board = new();

   always #5 clock = ~clock;

   cron_next_match_search u_top (.*);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         fire_board.check_fire('{rsp_found, rsp_out_year, rsp_out_month, rsp_out_day,
                                 rsp_out_hour, rsp_out_minute});
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic write_reg(int idx, logic [63:0] v);
      csr_valid <= 1'b1;
      csr_index <= CSR_INDEX_W'(idx);
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      fire_board.write_reg(idx, v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // valid stays up after the accepting edge; idling or drain() drops it
   task automatic send_query(logic [12:0] y, logic [3:0] m, logic [4:0] d,
                             logic [4:0] h, logic [5:0] mi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_year <= y;
      req_in_month <= m;
      req_in_day <= d;
      req_in_hour <= h;
      req_in_minute <= mi;
      do @(posedge clock); while (req_stall);
      fire_board.note_request(y, m, d, h, mi);
   endtask

   // every result back, plus slack for the block to return idle
   task automatic drain();
      req_valid <= 1'b0;
      while (fire_board.pending_fires.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic random_query();
      if ($urandom_range(9) == 0)
         send_query(13'($urandom), 4'($urandom), 5'($urandom), 5'($urandom), 6'($urandom));
      else
         send_query(13'($urandom_range(8000, 1970)), 4'($urandom_range(12, 1)),
                    5'($urandom_range(31, 1)), 5'($urandom_range(23)),
                    6'($urandom_range(59)));
   endtask

   // sparse schedule so the search has real work; keeps at least one bit most times
   task automatic random_config();
      write_reg(REG_MINUTE_MASK, ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                 : (64'd1 << $urandom_range(59)));
      write_reg(REG_HOUR_MASK, ($urandom_range(1)) ? 64'($urandom)
                               : (64'd1 << $urandom_range(23)));
      write_reg(REG_MDAY_MASK, ($urandom_range(1)) ? 64'($urandom)
                               : (64'd1 << $urandom_range(31)));
      write_reg(REG_MONTH_MASK, ($urandom_range(1)) ? 64'($urandom)
                                : (64'd1 << $urandom_range(12)));
      write_reg(REG_WDAY_MASK, 64'($urandom));
      write_reg(REG_MDAY_LIMITED, 64'($urandom));
      write_reg(REG_WDAY_LIMITED, 64'($urandom));
   endtask

   initial begin
      #1_000_000_000;
      $display("cron_next_match_search_tb: FAIL");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset masks: every minute matches
      send_query(13'd1970, 4'd1, 5'd1, 5'd0, 6'd0);
      send_query(13'd8000, 4'd12, 5'd31, 5'd23, 6'd59);
      send_query(13'd2024, 4'd2, 5'd29, 5'd23, 6'd59);
      send_query(13'd2023, 4'd0, 5'd0, 5'd31, 6'd63);
      send_query(13'd2023, 4'd15, 5'd31, 5'd0, 6'd0);
      send_query(13'd2023, 4'd2, 5'd31, 5'd12, 6'd30);
      send_query(13'd8191, 4'd12, 5'd31, 5'd23, 6'd59);
      send_query(13'd0, 4'd3, 5'd1, 5'd0, 6'd0);
      drain();
      // Feb 29 only: leap search, and century non-leap years
      write_reg(REG_MONTH_MASK, 64'h4);
      write_reg(REG_MDAY_MASK, 64'h2000_0000);
      write_reg(REG_MDAY_LIMITED, 64'd1);
      write_reg(REG_MINUTE_MASK, 64'd1 << 59);
      write_reg(REG_HOUR_MASK, 64'd1 << 23);
      send_query(13'd2097, 4'd3, 5'd1, 5'd0, 6'd0);
      send_query(13'd2024, 4'd2, 5'd29, 5'd23, 6'd59);
      send_query(13'd8189, 4'd1, 5'd1, 5'd0, 6'd0);
      drain();
      // both fields limited: mday 13 or Friday
      write_reg(REG_MONTH_MASK, 64'h1FFF);
      write_reg(REG_MDAY_MASK, 64'h2000);
      write_reg(REG_WDAY_MASK, 64'h20);
      write_reg(REG_WDAY_LIMITED, 64'd1);
      send_query(13'd2025, 4'd6, 5'd1, 5'd0, 6'd0);
      drain();
      write_reg(REG_MDAY_LIMITED, 64'd0);
      send_query(13'd2025, 4'd6, 5'd1, 5'd0, 6'd0);
      drain();
      // empty masks, not found
      write_reg(REG_MINUTE_MASK, 64'd0);
      send_query(13'd2000, 4'd1, 5'd1, 5'd0, 6'd0);
      drain();
      write_reg(REG_MINUTE_MASK, '1);
      write_reg(REG_HOUR_MASK, '1);
      write_reg(REG_MONTH_MASK, 64'd0);
      send_query(13'd2000, 4'd1, 5'd1, 5'd0, 6'd0);
      drain();
      write_reg(REG_MONTH_MASK, 64'h1FFE);
      write_reg(REG_WDAY_MASK, 64'd0);
      send_query(13'd2000, 4'd1, 5'd1, 5'd0, 6'd0);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 49 : 0;
         recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 32 : 0;
         for (int blk = 0; blk < 12; blk++) begin
            random_config();
            repeat (8) random_query();
            drain();
         end
      end

      if (fire_board.errors == 0)
         $display("cron_next_match_search_tb: PASS");
      else
         $display("cron_next_match_search_tb: FAIL");
      $finish;
   end
endmodule

/* files.f */
+incdir+src
src/cnms_pkg.sv
src/cnms_csr.sv
src/cnms_ctrl.sv
src/cnms_dp.sv
src/cron_next_match_search.sv
src/cnms_checker.sv
test/cron_next_match_search_tb.sv
